>>> sv/htpr_pkg.sv
// Shared types and constants for the heater time-proportion regulator.
package htpr_pkg;

  // Operating modes carried in the op field
  typedef enum logic [1:0] {
    MODE_TANK_ONOFF = 2'd0,
    MODE_TANK_PWM   = 2'd1,
    MODE_RIMS_PWM   = 2'd2
  } mode_t;

  // Configuration register indexes
  localparam logic [1:0] REG_WINDOW_MS          = 2'd0;
  localparam logic [1:0] REG_BOOST_MARGIN       = 2'd1;
  localparam logic [1:0] REG_RIMS_RISE_LIMIT    = 2'd2;
  localparam logic [1:0] REG_RIMS_OVER_SETPOINT = 2'd3;

  // Configuration reset values
  localparam logic [15:0] WINDOW_MS_RST          = 16'd5000;
  localparam logic [9:0]  BOOST_MARGIN_RST       = 10'd30;
  localparam logic [9:0]  RIMS_RISE_LIMIT_RST    = 10'd90;
  localparam logic [9:0]  RIMS_OVER_SETPOINT_RST = 10'd50;

  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  typedef struct packed {
    logic [15:0] window_ms;
    logic [9:0]  boost_margin;
    logic [9:0]  rims_rise_limit;
    logic [9:0]  rims_over_setpoint;
  } cfg_t;

  // One sample as held in the input register
  typedef struct packed {
    logic [1:0]         op;
    logic signed [11:0] setpoint;
    logic signed [11:0] actual_temp;
    logic signed [11:0] outlet_temp;
    logic signed [11:0] outside_temp;
    logic [10:0]        duty;
    logic               element_covered;
    logic [31:0]        now_ms;
  } item_t;

  // Decision handed from the decide logic to the top level
  typedef struct packed {
    logic heater_on;
    logic restart;
  } dec_t;

endpackage

>>> sv/htpr_if.sv
// Valid/ready channel interfaces for sample words and relay words.
interface htpr_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic signed [11:0] setpoint;
  logic signed [11:0] actual_temp;
  logic signed [11:0] outlet_temp;
  logic signed [11:0] outside_temp;
  logic [10:0]        duty;
  logic               element_covered;
  logic [31:0]        now_ms;

  modport source (
    output valid, op, setpoint, actual_temp, outlet_temp, outside_temp, duty,
           element_covered, now_ms,
    input  ready
  );
  modport sink (
    input  valid, op, setpoint, actual_temp, outlet_temp, outside_temp, duty,
           element_covered, now_ms,
    output ready
  );
  modport mon (
    input valid, ready, op, setpoint, actual_temp, outlet_temp, outside_temp, duty,
          element_covered, now_ms
  );
endinterface

interface htpr_out_if;
  logic valid;
  logic ready;
  logic heater_on;

  modport source (output valid, heater_on, input ready);
  modport sink (input valid, heater_on, output ready);
  modport mon (input valid, ready, heater_on);
endinterface

>>> sv/htpr_cfg.sv
// Configuration register bank with write-only port.
module htpr_cfg import htpr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the register index and merge the write word
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        REG_WINDOW_MS:          cfg_nxt.window_ms          = cfg_wdata;
        REG_BOOST_MARGIN:       cfg_nxt.boost_margin       = cfg_wdata[9:0];
        REG_RIMS_RISE_LIMIT:    cfg_nxt.rims_rise_limit    = cfg_wdata[9:0];
        REG_RIMS_OVER_SETPOINT: cfg_nxt.rims_over_setpoint = cfg_wdata[9:0];
        default:                cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_ms          <= WINDOW_MS_RST;
      cfg_r.boost_margin       <= BOOST_MARGIN_RST;
      cfg_r.rims_rise_limit    <= RIMS_RISE_LIMIT_RST;
      cfg_r.rims_over_setpoint <= RIMS_OVER_SETPOINT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> sv/htpr_decide.sv
// Relay decision for one sample: mode gating, time proportioning and boost.
module htpr_decide import htpr_pkg::*; (
  input  item_t       item,
  input  cfg_t        cfg,
  input  logic [31:0] window_start,
  output dec_t        dec
);

  logic signed [12:0] setp13;
  logic signed [12:0] act13;
  logic signed [12:0] outl13;
  logic signed [12:0] outs13;
  logic signed [12:0] act_boost;
  logic signed [12:0] act_rise;
  logic signed [12:0] setp_over;
  logic               below_setp;
  logic               boost_on;
  logic               rims_ok;
  logic [31:0]        elapsed;
  logic [41:0]        lhs;
  logic [26:0]        rhs;
  logic               prop_on;
  logic               prop_active;
  logic               tp_on;
  logic               tp_restart;
  logic               gate;

  // Widen temperatures so that offsets cannot overflow
  always_comb begin
    setp13    = {item.setpoint[11], item.setpoint};
    act13     = {item.actual_temp[11], item.actual_temp};
    outl13    = {item.outlet_temp[11], item.outlet_temp};
    outs13    = {item.outside_temp[11], item.outside_temp};
    act_boost = act13 + $signed({3'b000, cfg.boost_margin});
    act_rise  = act13 + $signed({3'b000, cfg.rims_rise_limit});
    setp_over = setp13 + $signed({3'b000, cfg.rims_over_setpoint});
  end

  // Check RIMS interlocks
  assign rims_ok = (outl13 < act_rise) && (outl13 < setp_over) &&
                   (outs13 < act13) && (outs13 < setp13);

  // Compare elapsed*1024 against window*duty exactly
  assign elapsed     = item.now_ms - window_start;
  assign lhs         = {elapsed, 10'b0};
  assign rhs         = {11'b0, cfg.window_ms} * {16'b0, item.duty};
  assign prop_on     = lhs < {15'b0, rhs};
  assign below_setp  = act13 < setp13;
  assign boost_on    = act_boost < setp13;
  assign prop_active = below_setp && (item.duty != 11'd0) && !item.duty[10];

  // Below setpoint, full duty forces on and partial duty follows the window; boost forces on
  always_comb begin
    tp_on = 1'b0;
    if (below_setp && item.duty != 11'd0) begin
      tp_on = item.duty[10] ? 1'b1 : prop_on;
    end
    if (boost_on) begin
      tp_on = 1'b1;
    end
  end

  assign tp_restart = prop_active && (elapsed > {16'b0, cfg.window_ms});

  // Select by mode
  always_comb begin
    gate        = 1'b0;
    dec.restart = 1'b0;
    dec.heater_on = 1'b0;
    unique case (item.op)
      MODE_TANK_ONOFF: begin
        dec.heater_on = item.element_covered && !below_setp && (act13 == setp13)
                        || (item.element_covered && below_setp);
      end
      MODE_TANK_PWM: begin
        gate = item.element_covered;
      end
      MODE_RIMS_PWM: begin
        gate = rims_ok;
      end
      default: begin
        gate = 1'b0;
      end
    endcase
    if (gate) begin
      dec.heater_on = tp_on;
      dec.restart   = tp_restart;
    end
  end

endmodule

>>> sv/heater_time_proportion_regulator_core.sv
// Top level: input register, relay decision, result register and window timer.
//
//   channel | dir | handshake        | word
//   --------+-----+------------------+----------------------------------------
//   in_ch   | in  | valid/ready      | op, temperatures, duty, covered, now_ms
//   out_ch  | out | valid/ready      | heater_on
//   cfg_*   | in  | write enable     | cfg_idx selects, cfg_wdata 16 bits
//
// One sample per clock while the result side is not stalled; an accepted sample passes
// through the input register and then the result register, around the decide logic.
// The window start register updates as a sample moves into the result register,
// so the next sample sees it at once.
// A stalled result still lets one more sample into the input register.
// Synchronous active-low reset restores register defaults and a zero window start.
module heater_time_proportion_regulator_core import htpr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  htpr_in_if.sink               in_ch,
  htpr_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t        cfg;
  item_t       in_item;
  item_t       s1_item_r;
  logic        s1_v_r;
  logic        out_v_r;
  logic        heater_r;
  logic [31:0] win_start_r;
  logic [31:0] win_start_nxt;
  dec_t        dec;
  logic        out_adv;
  logic        in_rdy;
  logic        in_acc;

  htpr_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Pack the incoming word
  always_comb begin
    in_item.op              = in_ch.op;
    in_item.setpoint        = in_ch.setpoint;
    in_item.actual_temp     = in_ch.actual_temp;
    in_item.outlet_temp     = in_ch.outlet_temp;
    in_item.outside_temp    = in_ch.outside_temp;
    in_item.duty            = in_ch.duty;
    in_item.element_covered = in_ch.element_covered;
    in_item.now_ms          = in_ch.now_ms;
  end

  // Advance when the stage ahead is empty or draining
  assign out_adv     = !out_v_r || out_ch.ready;
  assign in_rdy      = !s1_v_r || out_adv;
  assign in_acc      = in_ch.valid && in_rdy;
  assign in_ch.ready = in_rdy;

  // Hold the input word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_rdy) begin
      s1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= in_item;
    end
  end

  htpr_decide u_decide (
    .item         (s1_item_r),
    .cfg          (cfg),
    .window_start (win_start_r),
    .dec          (dec)
  );

  // Restart the window as the sample retires
  always_comb begin
    win_start_nxt = win_start_r;
    if (s1_v_r && out_adv && dec.restart) begin
      win_start_nxt = s1_item_r.now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_start_r <= 32'd0;
      out_v_r     <= 1'b0;
    end else begin
      win_start_r <= win_start_nxt;
      if (out_adv) begin
        out_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s1_v_r) begin
      heater_r <= dec.heater_on;
    end
  end

  assign out_ch.valid     = out_v_r;
  assign out_ch.heater_on = heater_r;

endmodule

>>> sv/htpr_checker.sv
// Port-level checks for the regulator core and their bind.
module htpr_checker (
  input logic         clk,
  input logic         rst_n,
  htpr_in_if.sink     in_ch,
  htpr_out_if.source  out_ch
);

  // Stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.heater_on))
    else $error("result word changed while stalled");

  // No result right after reset
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid after reset");

  // An empty result side never blocks input
  a_in_open: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready)
    else $error("input blocked with empty result register");

  // A word taken with an empty result side reaches the result register as a valid result
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && !out_ch.valid |=> ##1 out_ch.valid)
    else $error("accepted word produced no result");

endmodule

bind heater_time_proportion_regulator_core htpr_checker u_htpr_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);
